// ----- hw/rtl/arbs_pkg.sv -----
// Package: beat types, opcodes, controller states and command/status structs.
`default_nettype none

package arbs_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OPC_W     = 4;
    localparam int unsigned TAG_FLD_W = 5;
    localparam int unsigned TAG_EXT_W = 8;

    localparam logic [OPC_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OPC_W-1:0] OP_AUIPC = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB   = 4'd2;
    localparam logic [OPC_W-1:0] OP_XOR   = 4'd3;
    localparam logic [OPC_W-1:0] OP_OR    = 4'd4;
    localparam logic [OPC_W-1:0] OP_AND   = 4'd5;
    localparam logic [OPC_W-1:0] OP_SLL   = 4'd6;
    localparam logic [OPC_W-1:0] OP_SRL   = 4'd7;
    localparam logic [OPC_W-1:0] OP_SRA   = 4'd8;
    localparam logic [OPC_W-1:0] OP_SLT   = 4'd9;
    localparam logic [OPC_W-1:0] OP_SLTU  = 4'd10;
    localparam logic [OPC_W-1:0] OP_LUI   = 4'd11;
    localparam logic [OPC_W-1:0] OP_JAL   = 4'd12;
    localparam logic [OPC_W-1:0] OP_JALR  = 4'd13;

    localparam logic [DATA_W-1:0] CTL_MASK = 32'hFFFF_FFFE;

    typedef struct packed {
        logic                  dispatch_valid;
        logic [OPC_W-1:0]      opcode;
        logic [DATA_W-1:0]     src_one;
        logic [DATA_W-1:0]     src_two;
        logic [TAG_FLD_W-1:0]  dispatch_tag;
        logic                  squash_valid;
        logic [TAG_FLD_W-1:0]  squash_from_tag;
        logic                  bus_grant_valid;
        logic [TAG_FLD_W-1:0]  bus_grant_tag;
    } t_in_beat;

    typedef struct packed {
        logic                  accepted;
        logic                  buffer_full;
        logic                  buffer_empty;
        logic [DATA_W-1:0]     oldest_value;
        logic [TAG_FLD_W-1:0]  oldest_tag;
        logic                  oldest_is_control;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic scan_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/alu_result_buffer_with_squash_top.sv -----
// Top level: ALU result buffer with squash, controller plus datapath.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready    i_in_beat  (arbs_pkg::t_in_beat)
// out       output     o_out_valid / i_out_ready  o_out_beat (arbs_pkg::t_out_beat)
//
// Each in beat is one processor cycle: ALU evaluate, slot update, then a report.
// One in beat passes through capture (the accepting cycle), an update step, a
// scan over all SLOT_COUNT slots (one slot per cycle for the oldest-tag search)
// and a load step. The out beat turns valid once the load step registers it;
// the next in beat is taken only after the previous one's load step, when the
// controller is back in idle.
// Reset (synchronous, active low) clears all slot valid bits and the controller.
// A stalled out beat holds in the output register; the next in beat is taken
// and processed meanwhile, and waits in the load step only if the previous
// out beat is still not taken.

module alu_result_buffer_with_squash_top #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned TAG_BITS   = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire arbs_pkg::t_in_beat  i_in_beat,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output arbs_pkg::t_out_beat      o_out_beat
);

    arbs_pkg::t_cmd    cmd;
    arbs_pkg::t_status status;

    // Sequence each beat: capture, update slots, scan, load result.
    arbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Hold slots, evaluate the op and find the oldest valid slot.
    arbs_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_beat  (i_in_beat),
        .o_status   (status),
        .o_out_beat (o_out_beat)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/arbs_alu.sv -----
// RV32I integer ALU for dispatched ops, with control-op flag.
`default_nettype none

module arbs_alu (
    input  wire logic [arbs_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [arbs_pkg::DATA_W-1:0] i_a,
    input  wire logic [arbs_pkg::DATA_W-1:0] i_b,
    output logic      [arbs_pkg::DATA_W-1:0] o_value,
    output logic                             o_is_control
);

    logic [4:0]                  shamt;
    logic [arbs_pkg::DATA_W-1:0] sum;

    assign shamt = i_b[4:0];
    assign sum   = i_a + i_b;

    always_comb begin
        o_is_control = 1'b0;
        unique case (i_opcode)
            arbs_pkg::OP_ADD, arbs_pkg::OP_AUIPC: o_value = sum;
            arbs_pkg::OP_SUB:  o_value = i_a - i_b;
            arbs_pkg::OP_XOR:  o_value = i_a ^ i_b;
            arbs_pkg::OP_OR:   o_value = i_a | i_b;
            arbs_pkg::OP_AND:  o_value = i_a & i_b;
            arbs_pkg::OP_SLL:  o_value = i_a << shamt;
            arbs_pkg::OP_SRL:  o_value = i_a >> shamt;
            arbs_pkg::OP_SRA:  o_value = $unsigned($signed(i_a) >>> shamt);
            arbs_pkg::OP_SLT:  o_value = {31'd0, $signed(i_a) < $signed(i_b)};
            arbs_pkg::OP_SLTU: o_value = {31'd0, i_a < i_b};
            arbs_pkg::OP_LUI:  o_value = i_b;
            arbs_pkg::OP_JAL, arbs_pkg::OP_JALR: begin
                o_value      = sum & arbs_pkg::CTL_MASK;
                o_is_control = 1'b1;
            end
            default: o_value = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/arbs_datapath.sv -----
// Datapath: input capture, slot update, oldest-slot scan and output register.
`default_nettype none

module arbs_datapath #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned TAG_BITS   = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire arbs_pkg::t_cmd      i_cmd,
    input  wire arbs_pkg::t_in_beat  i_in_beat,
    output arbs_pkg::t_status        o_status,
    output arbs_pkg::t_out_beat      o_out_beat
);

    localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    function automatic logic older(input logic [TAG_BITS-1:0] a,
                                   input logic [TAG_BITS-1:0] b);
        logic [TAG_BITS-1:0] d;
        d = a - b;
        return d[TAG_BITS-1];
    endfunction

    function automatic logic [TAG_BITS-1:0] fit_tag(
        input logic [arbs_pkg::TAG_FLD_W-1:0] t);
        logic [arbs_pkg::TAG_EXT_W-1:0] w;
        w = {{(arbs_pkg::TAG_EXT_W - arbs_pkg::TAG_FLD_W){1'b0}}, t};
        return w[TAG_BITS-1:0];
    endfunction

    arbs_pkg::t_in_beat r_in;

    logic [SLOT_COUNT-1:0]       r_valid;
    logic [arbs_pkg::DATA_W-1:0] r_value [SLOT_COUNT];
    logic [TAG_BITS-1:0]         r_tag   [SLOT_COUNT];
    logic                        r_ctl   [SLOT_COUNT];

    logic                        r_accepted;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_have;
    logic                        r_full;
    logic                        r_empty;
    logic [TAG_BITS-1:0]         r_best_tag;
    logic [arbs_pkg::DATA_W-1:0] r_best_value;
    logic                        r_best_ctl;
    arbs_pkg::t_out_beat         r_out;

    logic [TAG_BITS-1:0]         dtag;
    logic [TAG_BITS-1:0]         sqtag;
    logic [TAG_BITS-1:0]         gtag;
    logic                        found;
    logic [IDX_W-1:0]            target;
    logic                        push;
    logic                        push_flushed;
    logic [arbs_pkg::DATA_W-1:0] alu_value;
    logic                        alu_ctl;
    logic [SLOT_COUNT-1:0]       n_valid;
    logic                        take;
    logic [arbs_pkg::TAG_EXT_W-1:0] best_ext;

    arbs_alu u_alu (
        .i_opcode     (r_in.opcode),
        .i_a          (r_in.src_one),
        .i_b          (r_in.src_two),
        .o_value      (alu_value),
        .o_is_control (alu_ctl)
    );

    assign dtag  = fit_tag(r_in.dispatch_tag);
    assign sqtag = fit_tag(r_in.squash_from_tag);
    assign gtag  = fit_tag(r_in.bus_grant_tag);

    // Lowest slot free before this step.
    always_comb begin
        found  = 1'b0;
        target = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && !r_valid[i]) begin
                found  = 1'b1;
                target = IDX_W'(i);
            end
        end
    end

    assign push         = r_in.dispatch_valid && found;
    assign push_flushed = r_in.squash_valid && !older(dtag, sqtag);

    // Grants and squashes remove slots; the pushed slot stays unless the squash flushes it.
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (push && target == IDX_W'(i)) begin
                n_valid[i] = !push_flushed;
            end else begin
                n_valid[i] = r_valid[i]
                    && !(r_in.bus_grant_valid && r_tag[i] == gtag)
                    && !(r_in.squash_valid && !older(r_tag[i], sqtag));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.update) begin
                r_valid <= n_valid;
                r_idx   <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_beat;
        end
        if (i_cmd.update && push) begin
            r_value[target] <= alu_value;
            r_tag[target]   <= dtag;
            r_ctl[target]   <= alu_ctl;
        end
    end

    // Scan one slot per cycle; ties keep the lower index.
    assign take = r_valid[r_idx] && (!r_have || older(r_tag[r_idx], r_best_tag));

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_accepted <= push;
            r_have     <= 1'b0;
            r_full     <= 1'b1;
            r_empty    <= 1'b1;
        end else if (i_cmd.scan_step) begin
            if (r_valid[r_idx]) begin
                r_empty <= 1'b0;
            end else begin
                r_full <= 1'b0;
            end
            if (take) begin
                r_have       <= 1'b1;
                r_best_tag   <= r_tag[r_idx];
                r_best_value <= r_value[r_idx];
                r_best_ctl   <= r_ctl[r_idx];
            end
        end
    end

    assign best_ext = arbs_pkg::TAG_EXT_W'(r_best_tag);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.accepted          <= r_accepted;
            r_out.buffer_full       <= r_full;
            r_out.buffer_empty      <= r_empty;
            r_out.oldest_value      <= r_have ? r_best_value : '0;
            r_out.oldest_tag        <= r_have ? best_ext[arbs_pkg::TAG_FLD_W-1:0] : '0;
            r_out.oldest_is_control <= r_have && r_best_ctl;
        end
    end

    assign o_status.scan_last = (r_idx == LAST_IDX);
    assign o_out_beat         = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/arbs_ctrl.sv -----
// Controller: sequences capture, slot update, scan and output load.
`default_nettype none

module arbs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire arbs_pkg::t_status i_status,
    output arbs_pkg::t_cmd         o_cmd
);

    arbs_pkg::t_state r_state;
    arbs_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arbs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            arbs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = arbs_pkg::ST_UPDATE;
                end
            end
            arbs_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = arbs_pkg::ST_SCAN;
            end
            arbs_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = arbs_pkg::ST_DONE;
                end
            end
            arbs_pkg::ST_DONE: begin
                // Hold until the output register is free or draining.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = arbs_pkg::ST_IDLE;
                end
            end
            default: n_state = arbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- dv/alu_result_buffer_with_squash_top_test.sv -----
// Testbench for the ALU result buffer with squash: directed steps, random traffic, scoreboard.
`default_nettype none

module alu_result_buffer_with_squash_top_test;

    localparam int unsigned DATA_W       = arbs_pkg::DATA_W;
    localparam int unsigned OPC_W        = arbs_pkg::OPC_W;
    localparam int unsigned TAG_FLD_W    = arbs_pkg::TAG_FLD_W;

    localparam int unsigned SLOTS        = 8;
    localparam int unsigned TAGW         = 5;
    localparam int unsigned HALF_PERIOD  = 10;
    localparam int unsigned BEAT_LATENCY = SLOTS + 3;
    localparam int unsigned DIR_ROWS     = 25;
    localparam int unsigned RANDOM_BEATS = 1700;
    localparam int unsigned QUIET_TAIL   = 200;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned MAX_PRINTS   = 30;

    // Opcodes 14 and 15 carry no operation and evaluate to zero.
    localparam logic [OPC_W-1:0] OP_VOID_LO = 4'd14;
    localparam logic [OPC_W-1:0] OP_VOID_HI = 4'd15;

    typedef struct packed {
        arbs_pkg::t_in_beat  beat;
        logic                has_exp;
        arbs_pkg::t_out_beat exp;
    } t_dir_row;

    localparam arbs_pkg::t_out_beat NO_EXP = '0;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    arbs_pkg::t_in_beat  i_in_beat;
    logic                o_out_valid;
    logic                i_out_ready;
    arbs_pkg::t_out_beat o_out_beat;

    // Slot image kept by the predictor.
    logic                 slot_live [SLOTS];
    logic [DATA_W-1:0]    slot_val  [SLOTS];
    logic [TAG_FLD_W-1:0] slot_tag  [SLOTS];
    logic                 slot_ctl  [SLOTS];
    logic                 last_push;

    arbs_pkg::t_out_beat pending_reports[$];
    t_dir_row            steps[DIR_ROWS];

    int unsigned mismatch_count = 0;
    int unsigned beats_sent     = 0;
    int unsigned reports_seen   = 0;
    int unsigned dispatch_drops = 0;
    int unsigned pushes_flushed = 0;
    int unsigned seen_full      = 0;
    int unsigned seen_empty     = 0;

    // Coordination between the beat sender and the result receiver.
    bit          long_hold_req = 1'b0;
    bit          quiet_tail    = 1'b0;
    bit          out_idle_on   = 1'b1;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;
    int unsigned rx_cycles     = 0;

    alu_result_buffer_with_squash_top #(
        .SLOT_COUNT(SLOTS),
        .TAG_BITS  (TAGW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Sequence-number age: a is older than b when (a - b) wraps into the top half.
    function automatic logic tag_is_older(logic [TAG_FLD_W-1:0] a, logic [TAG_FLD_W-1:0] b);
        logic [TAG_FLD_W-1:0] d;
        d = a - b;
        return d[TAGW-1];
    endfunction

    function automatic logic [DATA_W-1:0] alu_result(logic [OPC_W-1:0] opc,
                                                     logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (opc)
            arbs_pkg::OP_ADD, arbs_pkg::OP_AUIPC: return a + b;
            arbs_pkg::OP_SUB:                     return a - b;
            arbs_pkg::OP_XOR:                     return a ^ b;
            arbs_pkg::OP_OR:                      return a | b;
            arbs_pkg::OP_AND:                     return a & b;
            arbs_pkg::OP_SLL:                     return a << sh;
            arbs_pkg::OP_SRL:                     return a >> sh;
            arbs_pkg::OP_SRA:                     return $signed(a) >>> sh;
            arbs_pkg::OP_SLT:                     return {31'b0, $signed(a) < $signed(b)};
            arbs_pkg::OP_SLTU:                    return {31'b0, a < b};
            arbs_pkg::OP_LUI:                     return b;
            arbs_pkg::OP_JAL, arbs_pkg::OP_JALR:  return (a + b) & arbs_pkg::CTL_MASK;
            default:                              return '0;
        endcase
    endfunction

    // Advance the slot image by one processor cycle and form the report it yields.
    task automatic predict_step(input arbs_pkg::t_in_beat b, output arbs_pkg::t_out_beat r);
        logic              found, push, push_gone, have, drop, flush, full, empty;
        int                target, best;
        logic [DATA_W-1:0] value;
        found = 1'b0;
        target = 0;
        have = 1'b0;
        best = 0;
        full = 1'b1;
        empty = 1'b1;
        // Only slots free before this cycle may take the dispatch.
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && !slot_live[i]) begin
                target = i;
                found = 1'b1;
            end
        end
        push = b.dispatch_valid && found;
        push_gone = b.squash_valid && !tag_is_older(b.dispatch_tag, b.squash_from_tag);
        value = alu_result(b.opcode, b.src_one, b.src_two);
        for (int i = 0; i < SLOTS; i++) begin
            drop = b.bus_grant_valid && slot_live[i] && slot_tag[i] == b.bus_grant_tag;
            flush = b.squash_valid && slot_live[i]
                    && !tag_is_older(slot_tag[i], b.squash_from_tag);
            if (push && i == target) begin
                slot_val[i] = value;
                slot_tag[i] = b.dispatch_tag;
                slot_ctl[i] = (b.opcode == arbs_pkg::OP_JAL) || (b.opcode == arbs_pkg::OP_JALR);
                slot_live[i] = !push_gone;
            end else begin
                slot_live[i] = slot_live[i] && !drop && !flush;
            end
        end
        // Oldest search: ties keep the lower slot.
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
                empty = 1'b0;
                if (!have || tag_is_older(slot_tag[i], slot_tag[best])) begin
                    best = i;
                    have = 1'b1;
                end
            end else begin
                full = 1'b0;
            end
        end
        r = '0;
        r.accepted = push;
        r.buffer_full = full;
        r.buffer_empty = empty;
        if (have) begin
            r.oldest_value = slot_val[best];
            r.oldest_tag = slot_tag[best];
            r.oldest_is_control = slot_ctl[best];
        end
        last_push = push;
        if (b.dispatch_valid && !found) dispatch_drops++;
        if (push && push_gone) pushes_flushed++;
        if (full) seen_full++;
        if (empty) seen_empty++;
    endtask

    function automatic arbs_pkg::t_in_beat mk_in(logic dv, logic [OPC_W-1:0] opc,
                                                 logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                 logic [TAG_FLD_W-1:0] dtag,
                                                 logic sq, logic [TAG_FLD_W-1:0] sqtag,
                                                 logic gv, logic [TAG_FLD_W-1:0] gtag);
        arbs_pkg::t_in_beat x;
        x.dispatch_valid = dv;
        x.opcode = opc;
        x.src_one = a;
        x.src_two = b;
        x.dispatch_tag = dtag;
        x.squash_valid = sq;
        x.squash_from_tag = sqtag;
        x.bus_grant_valid = gv;
        x.bus_grant_tag = gtag;
        return x;
    endfunction

    function automatic arbs_pkg::t_out_beat mk_out(logic acc, logic full, logic empty,
                                                   logic [DATA_W-1:0] value,
                                                   logic [TAG_FLD_W-1:0] tag, logic ctl);
        arbs_pkg::t_out_beat x;
        x.accepted = acc;
        x.buffer_full = full;
        x.buffer_empty = empty;
        x.oldest_value = value;
        x.oldest_tag = tag;
        x.oldest_is_control = ctl;
        return x;
    endfunction

    // Operands lean on the corners: zero, all ones, sign boundary, small shift amounts.
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return DATA_W'($urandom_range(0, 63));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR: report %0d %s: got %h, want %h", reports_seen, what, got, want);
        mismatch_count++;
    endtask

    // Offer one beat, hold it until taken, then log what it should produce.
    task automatic send_beat(input arbs_pkg::t_in_beat b, input logic has_exp,
                             input arbs_pkg::t_out_beat typed);
        arbs_pkg::t_out_beat p;
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_step(b, p);
        pending_reports.push_back(has_exp ? typed : p);
        beats_sent++;
    endtask

    task automatic idle_gap(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Result receiver: random stall bursts, one long hold-off on request, none in the tail.
    always @(posedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 97 == 0) out_idle_on = ($urandom_range(0, 2) != 0);
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (out_idle_on && !quiet_tail && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every taken report with the oldest pending expectation.
    always @(posedge i_clk) begin : report_check
        arbs_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("arrived with nothing pending", o_out_beat.oldest_value, '0);
            end else begin
                want = pending_reports.pop_front();
                if (o_out_beat.accepted !== want.accepted)
                    report_mismatch("accepted", o_out_beat.accepted, want.accepted);
                if (o_out_beat.buffer_full !== want.buffer_full)
                    report_mismatch("buffer_full", o_out_beat.buffer_full, want.buffer_full);
                if (o_out_beat.buffer_empty !== want.buffer_empty)
                    report_mismatch("buffer_empty", o_out_beat.buffer_empty,
                                    want.buffer_empty);
                if (o_out_beat.oldest_value !== want.oldest_value)
                    report_mismatch("oldest_value", o_out_beat.oldest_value,
                                    want.oldest_value);
                if (o_out_beat.oldest_tag !== want.oldest_tag)
                    report_mismatch("oldest_tag", o_out_beat.oldest_tag, want.oldest_tag);
                if (o_out_beat.oldest_is_control !== want.oldest_is_control)
                    report_mismatch("oldest_is_control", o_out_beat.oldest_is_control,
                                    want.oldest_is_control);
            end
            reports_seen++;
        end
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        arbs_pkg::t_in_beat   beat;
        logic [TAG_FLD_W-1:0] next_tag;
        logic [TAG_FLD_W-1:0] live_tags[$];
        int unsigned          dispatch_pct;
        bit                   idle_on;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        i_out_ready = 1'b0;
        last_push = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_val[i] = '0;
            slot_tag[i] = '0;
            slot_ctl[i] = 1'b0;
        end

        //                   dv opcode              src_one       src_two
        //                   tag   sq sqtag gv gtag   has_exp  expected report
        steps[0]  = '{mk_in(0, arbs_pkg::OP_ADD,   32'h0,        32'h0,
                            5'd0,  0, 5'd0, 0, 5'd0), 1'b1, mk_out(0, 0, 1, 32'h0, 5'd0, 0)};
        steps[1]  = '{mk_in(1, arbs_pkg::OP_ADD,   32'hFFFFFFFF, 32'h1,
                            5'd0,  0, 5'd0, 0, 5'd0), 1'b1, mk_out(1, 0, 0, 32'h0, 5'd0, 0)};
        // Squash at the entry's own tag flushes it.
        steps[2]  = '{mk_in(0, arbs_pkg::OP_ADD,   32'h0,        32'h0,
                            5'd0,  1, 5'd0, 0, 5'd0), 1'b1, mk_out(0, 0, 1, 32'h0, 5'd0, 0)};
        // Control op: sum with bit 0 cleared, highest tag.
        steps[3]  = '{mk_in(1, arbs_pkg::OP_JAL,   32'h7FFFFFFF, 32'h2,
                            5'd31, 0, 5'd0, 0, 5'd0), 1'b1,
                      mk_out(1, 0, 0, 32'h80000000, 5'd31, 1)};
        steps[4]  = '{mk_in(0, arbs_pkg::OP_ADD,   32'h0,        32'h0,
                            5'd0,  0, 5'd0, 1, 5'd31), 1'b1, mk_out(0, 0, 1, 32'h0, 5'd0, 0)};
        steps[5]  = '{mk_in(1, arbs_pkg::OP_SUB,   32'h0,        32'h1,
                            5'd1,  0, 5'd0, 0, 5'd0), 1'b1,
                      mk_out(1, 0, 0, 32'hFFFFFFFF, 5'd1, 0)};
        steps[6]  = '{mk_in(1, arbs_pkg::OP_XOR,   32'hA5A5A5A5, 32'hFFFF0000,
                            5'd2,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        steps[7]  = '{mk_in(1, arbs_pkg::OP_OR,    32'h0F0F0F0F, 32'h80000001,
                            5'd3,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        steps[8]  = '{mk_in(1, arbs_pkg::OP_AND,   32'hFFFFFFFF, 32'h7FFFFFFF,
                            5'd4,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        // Shifts use only the low five bits of the second operand.
        steps[9]  = '{mk_in(1, arbs_pkg::OP_SLL,   32'h1,        32'hFFFFFFFF,
                            5'd5,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        steps[10] = '{mk_in(1, arbs_pkg::OP_SRL,   32'h80000000, 32'h1F,
                            5'd6,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        steps[11] = '{mk_in(1, arbs_pkg::OP_SRA,   32'h80000000, 32'h3F,
                            5'd7,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        steps[12] = '{mk_in(1, arbs_pkg::OP_SLT,   32'h80000000, 32'h0,
                            5'd8,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        // Full buffer: drop the dispatch.
        steps[13] = '{mk_in(1, arbs_pkg::OP_SLTU,  32'h0,        32'h1,
                            5'd9,  0, 5'd0, 0, 5'd0), 1'b1,
                      mk_out(0, 1, 0, 32'hFFFFFFFF, 5'd1, 0)};
        // A slot freed by a grant cannot take a dispatch in the same cycle.
        steps[14] = '{mk_in(1, arbs_pkg::OP_LUI,   32'h0,        32'hDEADBEEF,
                            5'd10, 0, 5'd0, 1, 5'd1), 1'b0, NO_EXP};
        // Grant matching no slot does nothing.
        steps[15] = '{mk_in(1, arbs_pkg::OP_LUI,   32'h0,        32'hDEADBEEF,
                            5'd10, 0, 5'd0, 1, 5'd20), 1'b0, NO_EXP};
        steps[16] = '{mk_in(1, arbs_pkg::OP_AUIPC, 32'h1000,     32'h234,
                            5'd11, 1, 5'd5, 0, 5'd0), 1'b0, NO_EXP};
        // Push flushed by a squash in its own cycle still counts as accepted.
        steps[17] = '{mk_in(1, arbs_pkg::OP_JALR,  32'h100,      32'h3,
                            5'd6,  1, 5'd6, 0, 5'd0), 1'b0, NO_EXP};
        steps[18] = '{mk_in(1, OP_VOID_LO,         32'hFFFFFFFF, 32'hFFFFFFFF,
                            5'd5,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        steps[19] = '{mk_in(1, OP_VOID_HI,         32'hFFFFFFFF, 32'h1,
                            5'd6,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        // Squash, grant and an older push in one cycle; oldest ties keep the lower slot.
        steps[20] = '{mk_in(1, arbs_pkg::OP_SLTU,  32'h0,        32'hFFFFFFFF,
                            5'd3,  1, 5'd5, 1, 5'd2), 1'b0, NO_EXP};
        steps[21] = '{mk_in(0, arbs_pkg::OP_ADD,   32'h0,        32'h0,
                            5'd0,  1, 5'd3, 0, 5'd0), 1'b1, mk_out(0, 0, 1, 32'h0, 5'd0, 0)};
        steps[22] = '{mk_in(1, arbs_pkg::OP_ADD,   32'hFFFFFFFF, 32'hFFFFFFFF,
                            5'd7,  0, 5'd0, 0, 5'd0), 1'b1,
                      mk_out(1, 0, 0, 32'hFFFFFFFE, 5'd7, 0)};
        steps[23] = '{mk_in(1, arbs_pkg::OP_XOR,   32'hA5A5A5A5, 32'hFFFFFFFF,
                            5'd7,  0, 5'd0, 0, 5'd0), 1'b0, NO_EXP};
        // Grant matching two slots removes both.
        steps[24] = '{mk_in(0, arbs_pkg::OP_ADD,   32'h0,        32'h0,
                            5'd0,  0, 5'd0, 1, 5'd7), 1'b1, mk_out(0, 0, 1, 32'h0, 5'd0, 0)};

        // Hold reset low, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        for (int k = 0; k < DIR_ROWS; k++) begin
            send_beat(steps[k].beat, steps[k].has_exp, steps[k].exp);
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 11));
        end

        // Random part: mostly in-order tags with grants aimed at live slots, some noise.
        next_tag = TAG_FLD_W'($urandom_range(0, 31));
        dispatch_pct = 60;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 128 == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
                dispatch_pct = $urandom_range(35, 90);
            end
            if (n == RANDOM_BEATS - QUIET_TAIL) quiet_tail = 1'b1;
            // Stall the result side for a long stretch; keep offering beats meanwhile.
            if (n == 400) long_hold_req = 1'b1;
            // Pause the sender until every pending report is back.
            if (n == 1000) begin
                idle_gap(1);
                wait_drained();
            end

            if ($urandom_range(0, 9) == 0) begin
                beat.dispatch_valid = 1'($urandom_range(0, 1));
                beat.opcode = OPC_W'($urandom_range(0, 15));
                beat.src_one = DATA_W'($urandom);
                beat.src_two = DATA_W'($urandom);
                beat.dispatch_tag = TAG_FLD_W'($urandom_range(0, 31));
                beat.squash_valid = ($urandom_range(0, 3) == 0);
                beat.squash_from_tag = TAG_FLD_W'($urandom_range(0, 31));
                beat.bus_grant_valid = 1'($urandom_range(0, 1));
                beat.bus_grant_tag = TAG_FLD_W'($urandom_range(0, 31));
            end else begin
                live_tags.delete();
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i]) live_tags.push_back(slot_tag[i]);
                beat.dispatch_valid = ($urandom_range(0, 99) < dispatch_pct);
                beat.opcode = OPC_W'($urandom_range(0, 15));
                beat.src_one = pick_operand();
                beat.src_two = pick_operand();
                beat.dispatch_tag = next_tag;
                beat.squash_valid = ($urandom_range(0, 24) == 0);
                beat.squash_from_tag = next_tag - TAG_FLD_W'($urandom_range(0, 9));
                beat.bus_grant_valid = ($urandom_range(0, 99) < 110 - dispatch_pct);
                if (live_tags.size() != 0)
                    beat.bus_grant_tag = live_tags[$urandom_range(0, live_tags.size() - 1)];
                else
                    beat.bus_grant_tag = TAG_FLD_W'($urandom_range(0, 31));
            end

            send_beat(beat, 1'b0, NO_EXP);

            // Refetch from the squash point; otherwise advance past an accepted dispatch.
            if (beat.squash_valid)
                next_tag = beat.squash_from_tag;
            else if (beat.dispatch_valid && last_push)
                next_tag = next_tag + 1'b1;

            if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0)
                idle_gap($urandom_range(1, 11));
        end

        idle_gap(1);
        wait_drained();
        repeat (BEAT_LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d beats (%0d directed), checked %0d reports, %0d dispatches dropped,",
                 beats_sent, DIR_ROWS, reports_seen, dispatch_drops);
        $display("%0d pushes flushed on arrival, buffer full %0d times and empty %0d times.",
                 pushes_flushed, seen_full, seen_empty);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d reports never arrived",
                     mismatch_count, pending_reports.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/arbs_pkg.sv
hw/rtl/arbs_alu.sv
hw/rtl/arbs_datapath.sv
hw/rtl/arbs_ctrl.sv
hw/rtl/alu_result_buffer_with_squash_top.sv
dv/alu_result_buffer_with_squash_top_test.sv
